// ===== rtl/core/esrp_pkg.sv =====
// Shared types and constants of the NEW-ENVIRON SEND request parser.
package esrp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int STEP_W      = 3;

    localparam logic [7:0] OBJ_VAR     = 8'd0;
    localparam logic [7:0] OBJ_ESC     = 8'd2;
    localparam logic [7:0] OBJ_USERVAR = 8'd3;

    typedef enum logic [2:0] {
        EV_OPEN  = 3'd0,
        EV_BYTE  = 3'd1,
        EV_CLOSE = 3'd2,
        EV_ERROR = 3'd3,
        EV_DONE  = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_OPEN,
        CMD_CLOSE_OPEN,
        CMD_ERROR,
        CMD_END_CLOSE,
        CMD_END_ERR,
        CMD_END_EMPTY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic       whole;
        logic       grp;
    } t_cmd;

    typedef struct packed {
        t_event     event_res;
        logic       grp;
        logic [7:0] name_byte;
        logic       whole_group;
        logic       faked;
        logic       failed;
        logic       last;
    } t_result;

endpackage

// ===== rtl/core/environ_send_request_parser_top.sv =====
// Top level of the NEW-ENVIRON SEND request parser.
//
// Input channel: queue-style push/full. One body byte (or an end-of-message
// marker on i_message_end) transfers at each edge with i_push high and o_full low.
// Result channel: queue-style empty/pop. While o_empty is low the oldest event
// is on the o_* result ports; it transfers at an edge with i_pop high.
// Events: open (with group), name byte, close (with whole-group flag),
// parse error, message done (with faked/failed flags). o_last marks the last
// event of each input transfer.
// The first event of a byte goes through the command queue and then the
// output register. Throughput: one event per cycle from the sequencer while
// the receiver does not stall; a byte that causes one event then sustains one
// byte per cycle. A boundary byte causes two events for a request switch or
// message end, one for the end of a failed message, five for an empty message.
// A command queue between the parser and the sequencer absorbs those bursts.
// Reset: synchronous, active low; the parser returns to the base state and
// the queue and output register empty.
// Receiver stall: the output register holds; the queue fills, then o_full rises.
module environ_send_request_parser_top #(
    parameter int P_QUEUE_DEPTH = esrp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_message_end,
    input  logic [7:0]  i_byte_value,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_event_res,
    output logic        o_group,
    output logic [7:0]  o_name_byte,
    output logic        o_whole_group,
    output logic        o_faked,
    output logic        o_failed,
    output logic        o_last
);

    logic               cmd_push;
    esrp_pkg::t_cmd     cmd_in;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    esrp_pkg::t_cmd     q_data;
    esrp_pkg::t_result  result;

    esrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_message_end (i_message_end),
        .i_byte_value  (i_byte_value),
        .i_q_full      (q_full),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in)
    );

    esrp_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    esrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_data),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_result    (result),
        .o_empty     (o_empty),
        .i_pop       (i_pop)
    );

    assign o_full        = q_full;
    assign o_event_res   = result.event_res;
    assign o_group       = result.grp;
    assign o_name_byte   = result.name_byte;
    assign o_whole_group = result.whole_group;
    assign o_faked       = result.faked;
    assign o_failed      = result.failed;
    assign o_last        = result.last;

endmodule

// ===== rtl/core/esrp_front.sv =====
// Front end: byte classifier and parse state machine that issues event commands.
module esrp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic            i_message_end,
    input  logic [7:0]      i_byte_value,
    input  logic            i_q_full,
    output logic            o_cmd_push,
    output esrp_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_BASE,
        ST_OPEN,
        ST_NAME,
        ST_ESC,
        ST_ERR
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic            accept;
    logic            starter;
    logic            is_user;
    logic            cmd_valid;
    esrp_pkg::t_cmd  cmd;

    assign accept  = i_push && !i_q_full;
    assign is_user = (i_byte_value == esrp_pkg::OBJ_USERVAR);
    assign starter = (i_byte_value == esrp_pkg::OBJ_VAR) || is_user;

    always_comb begin
        n_state   = r_state;
        cmd_valid = 1'b1;
        cmd.kind  = esrp_pkg::CMD_BYTE;
        cmd.data  = i_byte_value;
        cmd.whole = 1'b0;
        cmd.grp   = is_user;
        if (i_message_end) begin
            n_state = ST_BASE;
            unique case (r_state)
                ST_OPEN: begin
                    cmd.kind  = esrp_pkg::CMD_END_CLOSE;
                    cmd.whole = 1'b1;
                end
                ST_NAME, ST_ESC: begin
                    cmd.kind = esrp_pkg::CMD_END_CLOSE;
                end
                ST_ERR: begin
                    cmd.kind = esrp_pkg::CMD_END_ERR;
                end
                default: begin
                    cmd.kind = esrp_pkg::CMD_END_EMPTY;
                end
            endcase
        end else begin
            unique case (r_state)
                ST_OPEN, ST_NAME: begin
                    if (starter) begin
                        cmd.kind  = esrp_pkg::CMD_CLOSE_OPEN;
                        cmd.whole = (r_state == ST_OPEN);
                        n_state   = ST_OPEN;
                    end else begin
                        cmd.kind = esrp_pkg::CMD_BYTE;
                        n_state  = (i_byte_value == esrp_pkg::OBJ_ESC) ? ST_ESC : ST_NAME;
                    end
                end
                ST_ESC: begin
                    cmd.kind = esrp_pkg::CMD_BYTE;
                    n_state  = ST_NAME;
                end
                ST_ERR: begin
                    cmd_valid = 1'b0;
                end
                default: begin
                    if (starter) begin
                        cmd.kind = esrp_pkg::CMD_OPEN;
                        n_state  = ST_OPEN;
                    end else begin
                        cmd.kind = esrp_pkg::CMD_ERROR;
                        n_state  = ST_ERR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BASE;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    assign o_cmd_push = accept && cmd_valid;
    assign o_cmd      = cmd;

endmodule

// ===== rtl/core/esrp_fifo.sv =====
// Command queue between the front end and the event sequencer.
module esrp_fifo #(
    parameter int P_DEPTH = esrp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esrp_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output esrp_pkg::t_cmd  o_data,
    output logic            o_empty
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    esrp_pkg::t_cmd    r_mem [P_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] ptr);
        f_next = (ptr == PTR_W'(P_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/esrp_back.sv =====
// Back end: expands each command into its events and holds the output register.
module esrp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  esrp_pkg::t_cmd     i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    output esrp_pkg::t_result  o_result,
    output logic               o_empty,
    input  logic               i_pop
);

    logic [esrp_pkg::STEP_W-1:0]  r_step;
    logic                         r_out_valid;
    esrp_pkg::t_result            r_out;
    esrp_pkg::t_result            ev;
    logic                         load;

    always_comb begin
        ev           = '0;
        ev.event_res = esrp_pkg::EV_DONE;
        unique case (i_cmd.kind)
            esrp_pkg::CMD_BYTE: begin
                ev.event_res = esrp_pkg::EV_BYTE;
                ev.name_byte = i_cmd.data;
                ev.last      = 1'b1;
            end
            esrp_pkg::CMD_OPEN: begin
                ev.event_res = esrp_pkg::EV_OPEN;
                ev.grp       = i_cmd.grp;
                ev.last      = 1'b1;
            end
            esrp_pkg::CMD_CLOSE_OPEN: begin
                if (r_step == '0) begin
                    ev.event_res   = esrp_pkg::EV_CLOSE;
                    ev.whole_group = i_cmd.whole;
                end else begin
                    ev.event_res = esrp_pkg::EV_OPEN;
                    ev.grp       = i_cmd.grp;
                    ev.last      = 1'b1;
                end
            end
            esrp_pkg::CMD_ERROR: begin
                ev.event_res = esrp_pkg::EV_ERROR;
                ev.last      = 1'b1;
            end
            esrp_pkg::CMD_END_CLOSE: begin
                if (r_step == '0) begin
                    ev.event_res   = esrp_pkg::EV_CLOSE;
                    ev.whole_group = i_cmd.whole;
                end else begin
                    ev.event_res = esrp_pkg::EV_DONE;
                    ev.last      = 1'b1;
                end
            end
            esrp_pkg::CMD_END_ERR: begin
                ev.event_res = esrp_pkg::EV_DONE;
                ev.failed    = 1'b1;
                ev.last      = 1'b1;
            end
            esrp_pkg::CMD_END_EMPTY: begin
                priority if (r_step == esrp_pkg::STEP_W'(0)) begin
                    ev.event_res = esrp_pkg::EV_OPEN;
                end else if (r_step == esrp_pkg::STEP_W'(2)) begin
                    ev.event_res = esrp_pkg::EV_OPEN;
                    ev.grp       = 1'b1;
                end else if (r_step == esrp_pkg::STEP_W'(1)
                             || r_step == esrp_pkg::STEP_W'(3)) begin
                    ev.event_res   = esrp_pkg::EV_CLOSE;
                    ev.whole_group = 1'b1;
                end else begin
                    ev.event_res = esrp_pkg::EV_DONE;
                    ev.faked     = 1'b1;
                    ev.last      = 1'b1;
                end
            end
            default: begin
                ev.last = 1'b1;
            end
        endcase
    end

    assign load      = !i_cmd_empty && (!r_out_valid || i_pop);
    assign o_cmd_pop = load && ev.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_step      <= ev.last ? '0 : r_step + esrp_pkg::STEP_W'(1);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= ev;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

endmodule

// ===== rtl/core/esrp_checker.sv =====
// Port-level checker for the NEW-ENVIRON SEND request parser, with its bind.
module esrp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_empty,
    input  logic        i_pop,
    input  logic [2:0]  o_event_res,
    input  logic        o_group,
    input  logic [7:0]  o_name_byte,
    input  logic        o_whole_group,
    input  logic        o_faked,
    input  logic        o_failed,
    input  logic        o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_byte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_event_res == esrp_pkg::EV_BYTE |-> o_last)
        else $error("name byte event not last of its transfer");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_event_res == esrp_pkg::EV_DONE |-> o_last && !o_group
        && o_name_byte == 8'd0 && !o_whole_group && !(o_faked && o_failed))
        else $error("malformed done event");

    a_open_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_event_res == esrp_pkg::EV_OPEN |-> o_name_byte == 8'd0
        && !o_whole_group && !o_faked && !o_failed)
        else $error("open event carries stray fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_event_res) && $stable(o_name_byte)
        && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind environ_send_request_parser_top esrp_checker u_checker (.*);

// ===== tb/environ_send_request_parser_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the NEW-ENVIRON SEND request parser: directed and random byte streams, scoreboarded.
module environ_send_request_parser_top_tb;

    typedef enum logic [2:0] {
        PS_BASE,
        PS_OPEN,
        PS_NAME,
        PS_ESC,
        PS_ERR
    } t_parse_state;

    typedef enum int {
        RX_READY,
        RX_PATTERN,
        RX_HEAVY
    } t_rx_mode;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_push        = 1'b0;
    logic       i_message_end = 1'b0;
    logic [7:0] i_byte_value  = 8'd0;
    logic       i_pop         = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [2:0] o_event_res;
    logic       o_group;
    logic [7:0] o_name_byte;
    logic       o_whole_group;
    logic       o_faked;
    logic       o_failed;
    logic       o_last;

    esrp_pkg::t_result pending_events[$];
    esrp_pkg::t_result staged_events[$];
    esrp_pkg::t_result head_event;
    t_parse_state parse_q      = PS_BASE;
    t_rx_mode     rx_mode      = RX_READY;
    logic [15:0]  stall_pattern = 16'hFFFF;
    int           stall_idx    = 0;
    bit           gaps_on      = 1'b0;
    int           burst_left   = 0;
    int           live_items   = 0;
    int           err_count    = 0;

    environ_send_request_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_message_end (i_message_end),
        .i_byte_value  (i_byte_value),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_event_res   (o_event_res),
        .o_group       (o_group),
        .o_name_byte   (o_name_byte),
        .o_whole_group (o_whole_group),
        .o_faked       (o_faked),
        .o_failed      (o_failed),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void stage_event(input esrp_pkg::t_event ev, input logic grp,
                                        input logic [7:0] nb, input logic whole,
                                        input logic fk, input logic fl);
        esrp_pkg::t_result r;
        r.event_res   = ev;
        r.grp         = grp;
        r.name_byte   = nb;
        r.whole_group = whole;
        r.faked       = fk;
        r.failed      = fl;
        r.last        = 1'b0;
        staged_events.push_back(r);
    endfunction

    function automatic int parse_byte(input logic end_flag, input logic [7:0] b);
        esrp_pkg::t_result r;
        int                n;
        logic              starter;
        logic              is_user;
        is_user = (b == esrp_pkg::OBJ_USERVAR);
        starter = (b == esrp_pkg::OBJ_VAR) || is_user;
        if (end_flag) begin
            case (parse_q)
                PS_OPEN: begin
                    stage_event(esrp_pkg::EV_CLOSE, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    stage_event(esrp_pkg::EV_DONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                end
                PS_NAME, PS_ESC: begin
                    stage_event(esrp_pkg::EV_CLOSE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                    stage_event(esrp_pkg::EV_DONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                end
                PS_ERR: begin
                    stage_event(esrp_pkg::EV_DONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
                end
                default: begin
                    stage_event(esrp_pkg::EV_OPEN, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                    stage_event(esrp_pkg::EV_CLOSE, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    stage_event(esrp_pkg::EV_OPEN, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0);
                    stage_event(esrp_pkg::EV_CLOSE, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    stage_event(esrp_pkg::EV_DONE, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0);
                end
            endcase
            parse_q = PS_BASE;
        end else begin
            case (parse_q)
                PS_OPEN, PS_NAME: begin
                    if (starter) begin
                        stage_event(esrp_pkg::EV_CLOSE, 1'b0, 8'd0, parse_q == PS_OPEN,
                                    1'b0, 1'b0);
                        stage_event(esrp_pkg::EV_OPEN, is_user, 8'd0, 1'b0, 1'b0, 1'b0);
                        parse_q = PS_OPEN;
                    end else begin
                        stage_event(esrp_pkg::EV_BYTE, 1'b0, b, 1'b0, 1'b0, 1'b0);
                        parse_q = (b == esrp_pkg::OBJ_ESC) ? PS_ESC : PS_NAME;
                    end
                end
                PS_ESC: begin
                    stage_event(esrp_pkg::EV_BYTE, 1'b0, b, 1'b0, 1'b0, 1'b0);
                    parse_q = PS_NAME;
                end
                PS_ERR: begin
                end
                default: begin
                    if (starter) begin
                        stage_event(esrp_pkg::EV_OPEN, is_user, 8'd0, 1'b0, 1'b0, 1'b0);
                        parse_q = PS_OPEN;
                    end else begin
                        stage_event(esrp_pkg::EV_ERROR, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                        parse_q = PS_ERR;
                    end
                end
            endcase
        end
        n = staged_events.size();
        for (int i = 0; i < n; i++) begin
            r = staged_events[i];
            r.last = (i == n - 1);
            pending_events.push_back(r);
        end
        staged_events.delete();
        return n;
    endfunction

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_events.size() == 0) begin
                $error("unexpected transfer: event_res %0d", o_event_res);
                err_count++;
            end else begin
                head_event = pending_events.pop_front();
                check_field("event_res", head_event.event_res, o_event_res);
                check_field("group", head_event.grp, o_group);
                check_field("name_byte", head_event.name_byte, o_name_byte);
                check_field("whole_group", head_event.whole_group, o_whole_group);
                check_field("faked", head_event.faked, o_faked);
                check_field("failed", head_event.failed, o_failed);
                check_field("last", head_event.last, o_last);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_pop <= 1'b0;
        end else begin
            case (rx_mode)
                RX_PATTERN: i_pop <= stall_pattern[stall_idx];
                RX_HEAVY:   i_pop <= ($urandom_range(0, 5) == 0);
                default:    i_pop <= 1'b1;
            endcase
            stall_idx = (stall_idx + 1) % 16;
        end
    end

    task automatic send_item(input logic end_flag, input logic [7:0] b);
        int n;
        if (gaps_on && burst_left <= 0) begin
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        i_push        <= 1'b1;
        i_message_end <= end_flag;
        i_byte_value  <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        n = parse_byte(end_flag, b);
        if (n > 0) live_items++;
        burst_left--;
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_push <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] b;
        if ($urandom_range(0, 5) == 0) return esrp_pkg::OBJ_ESC;
        do b = 8'($urandom_range(0, 255));
        while (b == esrp_pkg::OBJ_VAR || b == esrp_pkg::OBJ_USERVAR);
        return b;
    endfunction

    task automatic send_wellformed_message();
        int         reqs;
        int         len;
        logic [7:0] b;
        reqs = $urandom_range(1, 3);
        for (int r = 0; r < reqs; r++) begin
            send_item(1'b0, $urandom_range(0, 1) ? esrp_pkg::OBJ_USERVAR : esrp_pkg::OBJ_VAR);
            len = $urandom_range(0, 4);
            for (int k = 0; k < len; k++) begin
                b = name_char();
                send_item(1'b0, b);
                if (b == esrp_pkg::OBJ_ESC && (k < len - 1 || $urandom_range(0, 2) != 0))
                    send_item(1'b0, 8'($urandom_range(0, 255)));
            end
        end
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise_message(input bit broken);
        int len;
        len = $urandom_range(0, 6);
        if (broken) send_item(1'b0, name_char());
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 1) == 0)
                send_item(1'b0, 8'($urandom_range(0, 3)));
            else
                send_item(1'b0, 8'($urandom_range(0, 255)));
        end
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_empty_message();
        send_item(1'b1, 8'hFF);
    endtask

    task automatic test_named_requests();
        send_item(1'b0, esrp_pkg::OBJ_VAR);
        send_item(1'b0, 8'h55);
        send_item(1'b0, esrp_pkg::OBJ_USERVAR);
        send_item(1'b0, esrp_pkg::OBJ_VAR);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_escapes();
        send_item(1'b0, esrp_pkg::OBJ_USERVAR);
        send_item(1'b0, esrp_pkg::OBJ_ESC);
        send_item(1'b0, esrp_pkg::OBJ_VAR);
        send_item(1'b0, 8'h01);
        send_item(1'b0, esrp_pkg::OBJ_ESC);
        send_item(1'b0, esrp_pkg::OBJ_ESC);
        send_item(1'b0, esrp_pkg::OBJ_ESC);
        send_item(1'b1, 8'hAA);
    endtask

    task automatic test_parse_error();
        send_item(1'b0, 8'h01);
        send_item(1'b0, esrp_pkg::OBJ_VAR);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'hFF);
    endtask

    task automatic test_whole_group_end();
        send_item(1'b0, esrp_pkg::OBJ_VAR);
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_drain_pause();
        send_wellformed_message();
        wait_for_drain();
        send_wellformed_message();
    endtask

    task automatic test_random_traffic(input int count, input bit gaps, input t_rx_mode mode);
        int target;
        int pick;
        target        = live_items + count;
        gaps_on       = gaps;
        burst_left    = 0;
        rx_mode       = mode;
        stall_pattern = 16'($urandom()) | 16'h0001;
        while (live_items < target) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
                send_wellformed_message();
            else if (pick == 7)
                send_noise_message(1'b0);
            else if (pick == 8)
                send_noise_message(1'b1);
            else
                test_empty_message();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_named_requests();
        test_escapes();
        test_parse_error();
        test_whole_group_end();

        test_random_traffic(75, 1'b0, RX_READY);
        test_random_traffic(75, 1'b1, RX_PATTERN);
        test_drain_pause();
        test_random_traffic(65, 1'b1, RX_HEAVY);

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("environ_send_request_parser_top_tb: clean");
        end else begin
            $display("environ_send_request_parser_top_tb: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("environ_send_request_parser_top_tb: errors");
        $finish;
    end

endmodule

// ===== environ_send_request_parser_top.f =====
rtl/core/esrp_pkg.sv
rtl/core/esrp_front.sv
rtl/core/esrp_fifo.sv
rtl/core/esrp_back.sv
rtl/core/environ_send_request_parser_top.sv
rtl/core/esrp_checker.sv
tb/environ_send_request_parser_top_tb.sv
